FILE: rtl/apq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package apq_pkg;

  localparam int TAG_W   = 16;
  localparam int PRIO_W  = 32;
  localparam int TOTAL_W = 7;

  localparam logic [2:0] FN_ENQ  = 3'd0;
  localparam logic [2:0] FN_DEQ  = 3'd1;
  localparam logic [2:0] FN_PEEK = 3'd2;
  localparam logic [2:0] FN_CHG  = 3'd3;
  localparam logic [2:0] FN_CLR  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               func;
    logic [TAG_W-1:0]         item_tag;
    logic signed [PRIO_W-1:0] item_priority;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]         out_tag;
    logic signed [PRIO_W-1:0] out_priority;
    logic [1:0]               status;
    logic [TOTAL_W-1:0]       entry_total;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_CHANGE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/array_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Unsorted priority queue of up to CAPACITY tagged entries held in one memory with a single
// read port and a single write port. Enqueue and clear go straight from IDLE to DONE. Peek and
// change priority walk every held entry once through the read port. Dequeue walks the table
// once to find the entry with the largest priority (the earliest one on a tie) and then,
// unless it is the last entry, moves every later entry down one place, one entry per cycle.
// Input is not taken while an operation is in progress; a finished result waits in DONE
// until the output register is free.
module array_priority_queue
  import apq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int TAG_BITS = 16
) (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  wire       out_stall,
  output out_item_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int EW = TW + PRIO_W;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  state_t        state_r, state_nxt;
  in_item_t      op_r, op_nxt;
  out_item_t     res_r, res_nxt;
  out_item_t     out_data_r, out_data_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          dv_r, dv_nxt;
  logic [AW-1:0] dv_idx_r, dv_idx_nxt;
  logic [EW-1:0] best_r, best_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  logic          issue;
  logic          last;
  logic          better;
  logic [CW-1:0] shift_start;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      dv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      dv_r        <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    rd_idx_r   <= rd_idx_nxt;
    dv_idx_r   <= dv_idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    dv_nxt        = 1'b0;
    dv_idx_nxt    = rd_idx_r[AW-1:0];
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_addr       = rd_idx_r[AW-1:0];
    issue         = rd_idx_r < count_r;
    last          = dv_r && (CW'(dv_idx_r) == count_r - CW'(1));
    better        = dv_r && ((dv_idx_r == '0) ||
                    ($signed(rd_data_r[PRIO_W-1:0]) > $signed(best_r[PRIO_W-1:0])));
    shift_start   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt              = in_data;
          res_nxt             = '0;
          res_nxt.status      = ST_OK;
          res_nxt.entry_total = TOTAL_W'(count_r);
          rd_idx_nxt          = '0;
          state_nxt           = S_DONE;
          case (in_data.func)
            FN_ENQ: begin
              if (count_r == CW'(CAPACITY)) begin
                res_nxt.status = ST_FULL;
              end else begin
                wr_en               = 1'b1;
                wr_addr             = count_r[AW-1:0];
                wr_data             = {in_data.item_tag[TW-1:0], in_data.item_priority};
                count_nxt           = count_r + CW'(1);
                res_nxt.entry_total = TOTAL_W'(count_r + CW'(1));
              end
            end
            FN_DEQ, FN_PEEK: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            FN_CHG: begin
              if (count_r != '0) begin
                state_nxt = S_CHANGE;
              end
            end
            FN_CLR: begin
              count_nxt           = '0;
              res_nxt.entry_total = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          dv_nxt     = 1'b1;
        end
        if (better) begin
          best_nxt     = rd_data_r;
          best_idx_nxt = dv_idx_r;
        end
        if (last) begin
          res_nxt.out_tag      = TAG_W'(best_nxt[EW-1:PRIO_W]);
          res_nxt.out_priority = best_nxt[PRIO_W-1:0];
          shift_start          = CW'(best_idx_nxt) + CW'(1);
          state_nxt            = S_DONE;
          if (op_r.func == FN_DEQ) begin
            if (shift_start < count_r) begin
              rd_idx_nxt = shift_start;
              dv_nxt     = 1'b0;
              state_nxt  = S_SHIFT;
            end else begin
              count_nxt           = count_r - CW'(1);
              res_nxt.entry_total = TOTAL_W'(count_r - CW'(1));
            end
          end
        end
      end

      S_SHIFT: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          dv_nxt     = 1'b1;
        end
        if (dv_r) begin
          wr_en   = 1'b1;
          wr_addr = dv_idx_r - AW'(1);
          wr_data = rd_data_r;
        end
        if (last) begin
          count_nxt           = count_r - CW'(1);
          res_nxt.entry_total = TOTAL_W'(count_r - CW'(1));
          state_nxt           = S_DONE;
        end
      end

      S_CHANGE: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          dv_nxt     = 1'b1;
        end
        if (dv_r && (rd_data_r[EW-1:PRIO_W] == op_r.item_tag[TW-1:0])) begin
          wr_en   = 1'b1;
          wr_addr = dv_idx_r;
          wr_data = {rd_data_r[EW-1:PRIO_W], op_r.item_priority};
        end
        if (last) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/apq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module apq_checker
  import apq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input out_item_t out_data
);

  // A result that is held back must keep its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An accepted transfer keeps the input closed for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |-> (out_data.entry_total == '0))
    else $error("empty status with entries held");

  a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |->
      (out_data.entry_total == TOTAL_W'(CAPACITY)))
    else $error("full status below capacity");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.out_tag == '0) && (out_data.out_priority == '0))
    else $error("flagged result carries an entry");

endmodule

bind array_priority_queue apq_checker #(
  .CAPACITY(CAPACITY)
) u_apq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
